// File: rtl/stpg_pkg.sv
package stpg_pkg;

    // fixed formats
    localparam int SAMPLE_BITS = 24;
    localparam int TABLE_STEPS = 200;
    localparam int MAX_BLOCK   = 4096;
    localparam int UNITY_GAIN  = 65536;
    localparam int RAMP_FRAC   = 12;
    localparam int PAN_HALF    = 100;
    localparam int PAN_SPAN    = 2 * PAN_HALF;

    // configuration widths
    localparam int MASTER_W   = 17;
    localparam int PAN_W      = 8;
    localparam int LAW_W      = 2;
    localparam int BLEN_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // datapath widths
    localparam int GAIN_W    = 18;
    localparam int PG_W      = 18;
    localparam int RUN_W     = GAIN_W + RAMP_FRAC + 1;
    localparam int G_W       = RUN_W - RAMP_FRAC;
    localparam int PROD_W    = SAMPLE_BITS + G_W;
    localparam int DVD_W     = GAIN_W + RAMP_FRAC;
    localparam int LEN_W     = $clog2(MAX_BLOCK + 1);
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int IDX_W     = $clog2(TABLE_STEPS + 1);
    localparam int Q_W       = $clog2(PAN_SPAN + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAN_POSITION = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PAN_LAW      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = CFG_IDX_W'(3);

    // pan law codes, any other code selects the root law
    localparam logic [LAW_W-1:0] LAW_LINEAR = LAW_W'(0);
    localparam logic [LAW_W-1:0] LAW_SINE   = LAW_W'(1);

    // reset values
    localparam logic [MASTER_W-1:0] MASTER_RESET = MASTER_W'(UNITY_GAIN);
    localparam logic [BLEN_W-1:0]   BLEN_RESET   = BLEN_W'(512);

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] SQRT2_Q30 = 64'd1518500250;

    typedef logic [PG_W-1:0]  pg_rom_t  [0:TABLE_STEPS];
    typedef logic [PG_W-1:0]  lin_rom_t [0:PAN_SPAN];
    typedef logic [IDX_W-1:0] idx_rom_t [0:PAN_SPAN];

    typedef struct packed {
        logic capture;
        logic block_begin;
        logic idx;
        logic look;
        logic mult;
        logic cmp;
        logic step_wr;
        logic prod;
        logic sat;
        logic load;
        logic chan;
    } dp_cmd_t;

    typedef struct packed {
        logic block_first;
        logic ramp_needed;
        logic div_done;
    } dp_stat_t;

    function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n   = n_in;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (n >= res + b) begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end
                else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // sqrt2 * sin(i/steps * pi/2) from a truncated odd series
    function automatic pg_rom_t build_sine_rom();
        pg_rom_t     rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i <= TABLE_STEPS; i++) begin
            x    = 64'(i) * PI_Q30 / 64'(2 * TABLE_STEPS);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + term;
            rom[i] = PG_W'((sum * SQRT2_Q30 + (64'd1 << 43)) >> 44);
        end
        return rom;
    endfunction

    // sqrt2 * sqrt(i/steps)
    function automatic pg_rom_t build_root_rom();
        pg_rom_t rom;
        for (int i = 0; i <= TABLE_STEPS; i++) begin
            rom[i] = PG_W'((int_sqrt((64'(i) << 35) / 64'(TABLE_STEPS)) + 64'd1) >> 1);
        end
        return rom;
    endfunction

    // linear law, n/100 in q2.16 rounded
    function automatic lin_rom_t build_lin_rom();
        lin_rom_t rom;
        for (int i = 0; i <= PAN_SPAN; i++) begin
            rom[i] = PG_W'((64'(i) * 64'(UNITY_GAIN) + 64'(PAN_HALF / 2)) / 64'(PAN_HALF));
        end
        return rom;
    endfunction

    // pan offset 0..200 to table index
    function automatic idx_rom_t build_idx_rom();
        idx_rom_t rom;
        for (int i = 0; i <= PAN_SPAN; i++) begin
            rom[i] = IDX_W'((64'(i) * 64'(TABLE_STEPS) + 64'(PAN_HALF)) / 64'(PAN_SPAN));
        end
        return rom;
    endfunction

    localparam pg_rom_t  SINE_ROM = build_sine_rom();
    localparam pg_rom_t  ROOT_ROM = build_root_rom();
    localparam lin_rom_t LIN_ROM  = build_lin_rom();
    localparam idx_rom_t IDX_ROM  = build_idx_rom();

endpackage

// File: rtl/stpg_if.sv
interface stpg_frame_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [stpg_pkg::SAMPLE_BITS-1:0] left_sample;
    logic signed [stpg_pkg::SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface stpg_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [stpg_pkg::SAMPLE_BITS-1:0] left_result;
    logic signed [stpg_pkg::SAMPLE_BITS-1:0] right_result;
    logic                                   ramping;

    modport source (output valid, output left_result, output right_result,
                    output ramping, input ready);
    modport sink   (input valid, input left_result, input right_result,
                    input ramping, output ready);
endinterface

interface stpg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [stpg_pkg::CFG_IDX_W-1:0]      index;
    logic [stpg_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/stpg_div.sv
module stpg_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [stpg_pkg::DVD_W-1:0]     dividend,
    input  logic [stpg_pkg::LEN_W-1:0]     divisor,
    output logic [stpg_pkg::DVD_W-1:0]     quotient,
    output logic                           done
);

    localparam int DVD_W = stpg_pkg::DVD_W;
    localparam int LEN_W = stpg_pkg::LEN_W;
    localparam int CNT_W = stpg_pkg::DIV_CNT_W;

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;

    // one restoring step per cycle, msb first
    always_comb begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        ge    = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: rtl/stpg_dp.sv
module stpg_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  stpg_pkg::dp_cmd_t                      cmd,
    output stpg_pkg::dp_stat_t                     stat,
    input  logic [stpg_pkg::MASTER_W-1:0]          master_gain,
    input  logic signed [stpg_pkg::PAN_W-1:0]      pan_position,
    input  logic [stpg_pkg::LAW_W-1:0]             pan_law,
    input  logic [stpg_pkg::BLEN_W-1:0]            block_length,
    input  logic signed [stpg_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [stpg_pkg::SAMPLE_BITS-1:0] right_sample,
    output logic signed [stpg_pkg::SAMPLE_BITS-1:0] left_result,
    output logic signed [stpg_pkg::SAMPLE_BITS-1:0] right_result,
    output logic                                   ramping
);

    localparam int SB        = stpg_pkg::SAMPLE_BITS;
    localparam int GAIN_W    = stpg_pkg::GAIN_W;
    localparam int PG_W      = stpg_pkg::PG_W;
    localparam int RUN_W     = stpg_pkg::RUN_W;
    localparam int G_W       = stpg_pkg::G_W;
    localparam int PROD_W    = stpg_pkg::PROD_W;
    localparam int DVD_W     = stpg_pkg::DVD_W;
    localparam int LEN_W     = stpg_pkg::LEN_W;
    localparam int IDX_W     = stpg_pkg::IDX_W;
    localparam int Q_W       = stpg_pkg::Q_W;
    localparam int PAN_W     = stpg_pkg::PAN_W;
    localparam int MASTER_W  = stpg_pkg::MASTER_W;
    localparam int BLEN_W    = stpg_pkg::BLEN_W;
    localparam int RFRAC     = stpg_pkg::RAMP_FRAC;
    localparam int MP_W      = MASTER_W + PG_W + 1;
    localparam int Y_W       = PROD_W - 16;

    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

    // block state
    logic [LEN_W-1:0]        pos_reg;
    logic [LEN_W-1:0]        pos_next;
    logic                    started_reg;
    logic                    started_next;
    logic                    ramp_reg;
    logic                    ramp_next;
    logic [GAIN_W-1:0]       prev_reg [2];
    logic [GAIN_W-1:0]       prev_next [2];
    logic signed [RUN_W-1:0] run_reg [2];
    logic signed [RUN_W-1:0] run_next [2];
    logic signed [RUN_W-1:0] step_reg [2];
    logic signed [RUN_W-1:0] step_next [2];

    // working registers
    logic signed [SB-1:0]     samp_reg [2];
    logic [IDX_W-1:0]         idx_reg;
    logic [Q_W-1:0]           num_reg;
    logic [PG_W-1:0]          pg_reg;
    logic [GAIN_W-1:0]        tgt_reg;
    logic                     neg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SB-1:0]     res_reg [2];
    logic signed [SB-1:0]     out_l_reg;
    logic signed [SB-1:0]     out_r_reg;
    logic                     out_ramp_reg;

    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W-1:0]         pos_inc;
    logic [MASTER_W-1:0]      m_clamp;
    logic signed [PAN_W:0]    psum;
    logic [Q_W-1:0]           q;
    logic [IDX_W-1:0]         r_idx;
    logic [PG_W-1:0]          pg_sel;
    logic [MP_W-1:0]          mp;
    logic [GAIN_W-1:0]        eff_prev;
    logic [GAIN_W-1:0]        abs_diff;
    logic                     ramp_needed;
    logic                     div_start;
    logic [DVD_W-1:0]         quotient;
    logic                     div_done;
    logic signed [RUN_W-1:0]  qs;
    logic signed [RUN_W-1:0]  run_sel;
    logic signed [G_W-1:0]    g_sel;
    logic signed [SB-1:0]     s_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rnd;
    logic signed [Y_W-1:0]    y;
    logic signed [SB-1:0]     sat;

    // effective length, zero acts as one, lengths above 4096 act as 4096
    always_comb begin
        if (block_length == '0) begin
            len_eff = LEN_W'(1);
        end
        else if (block_length > BLEN_W'(stpg_pkg::MAX_BLOCK)) begin
            len_eff = LEN_W'(stpg_pkg::MAX_BLOCK);
        end
        else begin
            len_eff = LEN_W'(block_length);
        end
    end

    assign m_clamp = (master_gain > MASTER_W'(stpg_pkg::UNITY_GAIN))
                   ? MASTER_W'(stpg_pkg::UNITY_GAIN) : master_gain;

    // pan offset, clamped to 0..200
    always_comb begin
        psum = {pan_position[PAN_W-1], pan_position} + (PAN_W+1)'(stpg_pkg::PAN_HALF);
        if (psum[PAN_W]) begin
            q = '0;
        end
        else if (psum > $signed((PAN_W+1)'(stpg_pkg::PAN_SPAN))) begin
            q = Q_W'(stpg_pkg::PAN_SPAN);
        end
        else begin
            q = psum[Q_W-1:0];
        end
    end

    assign r_idx = stpg_pkg::IDX_ROM[q];

    always_comb begin
        if (pan_law == stpg_pkg::LAW_LINEAR) begin
            pg_sel = stpg_pkg::LIN_ROM[num_reg];
        end
        else if (pan_law == stpg_pkg::LAW_SINE) begin
            pg_sel = stpg_pkg::SINE_ROM[idx_reg];
        end
        else begin
            pg_sel = stpg_pkg::ROOT_ROM[idx_reg];
        end
    end

    assign mp = MP_W'(m_clamp) * MP_W'(pg_reg) + MP_W'(32768);

    // first block loads the target as its own previous gain
    assign eff_prev    = started_reg ? prev_reg[cmd.chan] : tgt_reg;
    assign ramp_needed = tgt_reg != eff_prev;
    assign abs_diff    = (tgt_reg >= eff_prev) ? tgt_reg - eff_prev : eff_prev - tgt_reg;
    assign div_start   = cmd.cmp && ramp_needed;

    stpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({abs_diff, {RFRAC{1'b0}}}),
        .divisor  (len_eff),
        .quotient (quotient),
        .done     (div_done)
    );

    assign qs = $signed({1'b0, quotient});

    // sample times floor of running gain
    assign run_sel   = run_reg[cmd.chan];
    assign g_sel     = $signed(run_sel[RUN_W-1:RFRAC]);
    assign s_sel     = samp_reg[cmd.chan];
    assign prod_next = s_sel * g_sel;

    always_comb begin
        rnd = prod_reg + PROD_W'(32768);
        y   = $signed(rnd[PROD_W-1:16]);
        if (y > Y_MAX) begin
            sat = Y_MAX[SB-1:0];
        end
        else if (y < Y_MIN) begin
            sat = Y_MIN[SB-1:0];
        end
        else begin
            sat = y[SB-1:0];
        end
    end

    assign pos_inc = pos_reg + LEN_W'(1);

    always_comb begin
        pos_next     = pos_reg;
        started_next = started_reg;
        ramp_next    = ramp_reg;
        for (int c = 0; c < 2; c++) begin
            prev_next[c] = prev_reg[c];
            run_next[c]  = run_reg[c];
            step_next[c] = step_reg[c];
        end

        if (cmd.block_begin) begin
            ramp_next = 1'b0;
        end
        if (cmd.cmp) begin
            prev_next[cmd.chan] = tgt_reg;
            run_next[cmd.chan]  = $signed({1'b0, eff_prev, {RFRAC{1'b0}}});
            if (ramp_needed) begin
                ramp_next = 1'b1;
            end
            else begin
                step_next[cmd.chan] = '0;
            end
            if (cmd.chan) begin
                started_next = 1'b1;
            end
        end
        if (cmd.step_wr) begin
            step_next[cmd.chan] = neg_reg ? -qs : qs;
        end
        if (cmd.load) begin
            for (int c = 0; c < 2; c++) begin
                run_next[c] = run_reg[c] + step_reg[c];
            end
            pos_next = (pos_inc >= len_eff) ? '0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg     <= '0;
            started_reg <= 1'b0;
            ramp_reg    <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                prev_reg[c] <= '0;
                run_reg[c]  <= '0;
                step_reg[c] <= '0;
            end
        end
        else begin
            pos_reg     <= pos_next;
            started_reg <= started_next;
            ramp_reg    <= ramp_next;
            for (int c = 0; c < 2; c++) begin
                prev_reg[c] <= prev_next[c];
                run_reg[c]  <= run_next[c];
                step_reg[c] <= step_next[c];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            samp_reg[0] <= left_sample;
            samp_reg[1] <= right_sample;
        end
        if (cmd.idx) begin
            idx_reg <= cmd.chan ? r_idx : IDX_W'(stpg_pkg::TABLE_STEPS) - r_idx;
            num_reg <= cmd.chan ? q : Q_W'(stpg_pkg::PAN_SPAN) - q;
        end
        if (cmd.look) begin
            pg_reg <= pg_sel;
        end
        if (cmd.mult) begin
            tgt_reg <= mp[GAIN_W+15:16];
        end
        if (cmd.cmp) begin
            neg_reg <= tgt_reg < eff_prev;
        end
        if (cmd.prod) begin
            prod_reg <= prod_next;
        end
        if (cmd.sat) begin
            res_reg[cmd.chan] <= sat;
        end
        if (cmd.load) begin
            out_l_reg    <= res_reg[0];
            out_r_reg    <= res_reg[1];
            out_ramp_reg <= ramp_reg;
        end
    end

    assign stat.block_first = pos_reg == '0;
    assign stat.ramp_needed = ramp_needed;
    assign stat.div_done    = div_done;

    assign left_result  = out_l_reg;
    assign right_result = out_r_reg;
    assign ramping      = out_ramp_reg;

endmodule

// File: rtl/stpg_ctrl.sv
module stpg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  stpg_pkg::dp_stat_t stat,
    output stpg_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_IDX   = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_MULT  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_PROD  = 3'd6;
    localparam logic [2:0] S_SAT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       chan_reg;
    logic       chan_next;
    logic       wr_reg;
    logic       wr_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load;

    // the write step parks in idle with wr set until the output register frees
    assign load        = wr_reg && (!out_valid_reg || result_ready);
    assign frame_ready = (state_reg == S_IDLE) && !wr_reg;

    always_comb begin
        cmd            = '0;
        cmd.chan       = chan_reg;
        cmd.load       = load;
        state_next     = state_reg;
        chan_next      = chan_reg;
        wr_next        = wr_reg && !load;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !result_ready);

        unique case (state_reg)
            S_IDLE: begin
                if (frame_ready && frame_valid) begin
                    cmd.capture = 1'b1;
                    chan_next   = 1'b0;
                    state_next  = stat.block_first ? S_IDX : S_PROD;
                end
            end
            S_IDX: begin
                cmd.idx         = 1'b1;
                cmd.block_begin = !chan_reg;
                state_next      = S_LOOK;
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_MULT;
            end
            S_MULT: begin
                cmd.mult   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                if (stat.ramp_needed) begin
                    state_next = S_DIV;
                end
                else begin
                    chan_next  = !chan_reg;
                    state_next = chan_reg ? S_PROD : S_IDX;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.step_wr = 1'b1;
                    chan_next   = !chan_reg;
                    state_next  = chan_reg ? S_PROD : S_IDX;
                end
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = S_SAT;
            end
            S_SAT: begin
                cmd.sat   = 1'b1;
                chan_next = !chan_reg;
                if (chan_reg) begin
                    wr_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else begin
                    state_next = S_PROD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            chan_reg      <= 1'b0;
            wr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: rtl/stereo_pan_law_gain_ramp.sv
// frame path: capture, then on a frame that opens a block a target lookup
// per channel (index, lookup, multiply, compare) plus a serial divide per
// ramping channel, then a shared multiplier scales both channels in turn and
// saturates them; a new frame is taken once the last result is in the output register
// reset: rst_n async low clears control and ramp state, registers take defaults
// (unity master, center pan, linear law, 512 frame blocks); no clearing pass
module stereo_pan_law_gain_ramp (
    input  logic          clk,
    input  logic          rst_n,
    stpg_frame_if.sink    frame,
    stpg_result_if.source result,
    stpg_cfg_if.sink      cfg
);

    // configuration registers, to be written by the user between frames; the block does not enforce it
    logic [stpg_pkg::MASTER_W-1:0]     master_gain_reg;
    logic [stpg_pkg::MASTER_W-1:0]     master_gain_next;
    logic signed [stpg_pkg::PAN_W-1:0] pan_position_reg;
    logic signed [stpg_pkg::PAN_W-1:0] pan_position_next;
    logic [stpg_pkg::LAW_W-1:0]        pan_law_reg;
    logic [stpg_pkg::LAW_W-1:0]        pan_law_next;
    logic [stpg_pkg::BLEN_W-1:0]       block_length_reg;
    logic [stpg_pkg::BLEN_W-1:0]       block_length_next;

    stpg_pkg::dp_cmd_t  cmd;
    stpg_pkg::dp_stat_t stat;

    // config port never stalls
    assign cfg.ready = 1'b1;

    // each register keeps only its own width of the write data
    always_comb begin
        master_gain_next  = master_gain_reg;
        pan_position_next = pan_position_reg;
        pan_law_next      = pan_law_reg;
        block_length_next = block_length_reg;
        if (cfg.valid) begin
            unique case (cfg.index)
                stpg_pkg::REG_MASTER_GAIN: begin
                    master_gain_next = cfg.data[stpg_pkg::MASTER_W-1:0];
                end
                stpg_pkg::REG_PAN_POSITION: begin
                    pan_position_next = $signed(cfg.data[stpg_pkg::PAN_W-1:0]);
                end
                stpg_pkg::REG_PAN_LAW: begin
                    pan_law_next = cfg.data[stpg_pkg::LAW_W-1:0];
                end
                stpg_pkg::REG_BLOCK_LENGTH: begin
                    block_length_next = cfg.data[stpg_pkg::BLEN_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            master_gain_reg  <= stpg_pkg::MASTER_RESET;
            pan_position_reg <= '0;
            pan_law_reg      <= stpg_pkg::LAW_LINEAR;
            block_length_reg <= stpg_pkg::BLEN_RESET;
        end
        else begin
            master_gain_reg  <= master_gain_next;
            pan_position_reg <= pan_position_next;
            pan_law_reg      <= pan_law_next;
            block_length_reg <= block_length_next;
        end
    end

    // sequencer: block start work per channel, then two multiply and
    // saturate passes, then the output register load
    stpg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame.valid),
        .frame_ready  (frame.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // gain tables, target multiply, ramp divider, sample scaling and
    // the output register that decouples the result side
    stpg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .master_gain  (master_gain_reg),
        .pan_position (pan_position_reg),
        .pan_law      (pan_law_reg),
        .block_length (block_length_reg),
        .left_sample  (frame.left_sample),
        .right_sample (frame.right_sample),
        .left_result  (result.left_result),
        .right_result (result.right_result),
        .ramping      (result.ramping)
    );

endmodule
